### hdl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd1;

  // command from the sequencer to the modular multiplier
  typedef struct packed {
    logic start;     // load operands and begin
    logic red_mode;  // reduce op_b mod op_m instead of multiplying
  } mm_cmd_t;

endpackage

### hdl/modexp_mulmod.sv
// Bit-serial shift-add modular multiplier, also used to reduce a word mod m.
module modexp_mulmod #(
  parameter int WORD_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  modexp_pkg::mm_cmd_t      cmd,
  input  logic [WORD_BITS-1:0]     op_a,
  input  logic [WORD_BITS-1:0]     op_b,
  input  logic [WORD_BITS-1:0]     op_m,
  output logic                     done,
  output logic [WORD_BITS-1:0]     res
);
  import modexp_pkg::*;

  localparam int CW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] b_r;
  logic [WORD_BITS-1:0] m_r;
  logic [CW-1:0]        cnt_r;
  logic                 phase_r;
  logic                 mode_r;
  logic                 run_r;
  logic                 done_r;

  logic                 bit_in;
  logic [WORD_BITS:0]   p;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] red_val;

  // phase 0: acc = 2*acc (+ bit in reduce mode); phase 1: acc = acc + a.
  // Both sums stay below 2*m, so one conditional subtract reduces them.
  always_comb begin
    bit_in = b_r[WORD_BITS-1];
    if (phase_r) begin
      p = {1'b0, acc_r} + {1'b0, a_r};
    end else begin
      p = {acc_r, mode_r & bit_in};
    end
    diff = p - {1'b0, m_r};
    if (p >= {1'b0, m_r}) begin
      red_val = diff[WORD_BITS-1:0];
    end else begin
      red_val = p[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        run_r   <= 1'b1;
        phase_r <= 1'b0;
        mode_r  <= cmd.red_mode;
        acc_r   <= '0;
        a_r     <= op_a;
        b_r     <= op_b;
        m_r     <= op_m;
        cnt_r   <= CW'(WORD_BITS - 1);
      end else if (run_r) begin
        acc_r <= red_val;
        if (!phase_r && !mode_r && bit_in) begin
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          b_r     <= {b_r[WORD_BITS-2:0], 1'b0};
          if (cnt_r == '0) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

### hdl/modular_exponentiation.sv
// Top level: left-to-right square-and-multiply modular exponentiation.
//
// Each transfer on the input (start high while busy is low) takes one base and
// returns base^exponent mod modulus as a single out_valid pulse; the result
// cannot be held off and must be taken in that cycle. Exponent and modulus
// must be written through the cfg port only while busy is low; the block
// itself does not enforce this. All work goes through one bit-serial modular
// multiplier that handles one multiplier bit per cycle, except that a one bit
// while multiplying also needs an add step. An item first reduces the base
// mod the modulus (the exponent's top set bit is found at the same time),
// then for each exponent bit below the top set bit does one squaring and, if
// the bit is one, one multiplication. Exponent zero or modulus zero bypass
// the multiplier. Busy stays high for the whole item, except that exponent
// zero or modulus zero never raise it.
module modular_exponentiation #(
  parameter int WORD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [WORD_BITS-1:0]                in_base,
  output logic                                out_valid,
  output logic [WORD_BITS-1:0]                out_power,
  input  logic                                cfg_we,
  input  logic [modexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_data
);
  import modexp_pkg::*;

  localparam int EW = $clog2(WORD_BITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_SQR  = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0]           state_r;
  logic [WORD_BITS-1:0] exp_r;
  logic [WORD_BITS-1:0] mod_r;
  logic [WORD_BITS-1:0] m_r;
  logic [WORD_BITS-1:0] xr_r;
  logic [WORD_BITS-1:0] e_r;
  logic [EW-1:0]        ebits_r;
  logic                 norm_done_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_power_r;

  mm_cmd_t              mm_cmd;
  logic [WORD_BITS-1:0] mm_a;
  logic [WORD_BITS-1:0] mm_b;
  logic [WORD_BITS-1:0] mm_m;
  logic                 mm_done;
  logic [WORD_BITS-1:0] mm_res;

  modexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mm_cmd),
    .op_a  (mm_a),
    .op_b  (mm_b),
    .op_m  (mm_m),
    .done  (mm_done),
    .res   (mm_res)
  );

  // The running value lives in the multiplier's accumulator between ops.
  always_comb begin
    mm_cmd = '0;
    mm_a   = mm_res;
    mm_b   = mm_res;
    mm_m   = m_r;
    case (state_r)
      S_IDLE: begin
        mm_a = '0;
        mm_b = in_base;
        mm_m = mod_r;
        if (start && mod_r != '0 && exp_r != '0) begin
          mm_cmd.start    = 1'b1;
          mm_cmd.red_mode = 1'b1;
        end
      end
      S_RED: begin
        if (mm_done && ebits_r != '0) begin
          mm_cmd.start = 1'b1;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          if (e_r[WORD_BITS-1]) begin
            mm_cmd.start = 1'b1;
            mm_a         = xr_r;
          end else if (ebits_r != EW'(1)) begin
            mm_cmd.start = 1'b1;
          end
        end
      end
      S_MUL: begin
        if (mm_done && ebits_r != EW'(1)) begin
          mm_cmd.start = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= WORD_BITS'(1);
      mod_r       <= '1;
      norm_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_EXPONENT: exp_r <= cfg_data;
          REG_MODULUS:  mod_r <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            m_r <= mod_r;
            if (mod_r == '0) begin
              out_valid_r <= 1'b1;
              out_power_r <= '0;
            end else if (exp_r == '0) begin
              // 1 mod m
              out_valid_r <= 1'b1;
              out_power_r <= (mod_r == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            end else begin
              e_r         <= exp_r;
              ebits_r     <= EW'(WORD_BITS);
              norm_done_r <= 1'b0;
              state_r     <= S_RED;
            end
          end
        end
        S_RED: begin
          // shift out leading zeros and the top set bit while the base reduces
          if (!norm_done_r) begin
            e_r     <= {e_r[WORD_BITS-2:0], 1'b0};
            ebits_r <= ebits_r - EW'(1);
            if (e_r[WORD_BITS-1]) begin
              norm_done_r <= 1'b1;
            end
          end
          if (mm_done) begin
            xr_r <= mm_res;
            if (ebits_r == '0) begin
              out_valid_r <= 1'b1;
              out_power_r <= mm_res;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mm_done) begin
            if (e_r[WORD_BITS-1]) begin
              state_r <= S_MUL;
            end else begin
              e_r     <= {e_r[WORD_BITS-2:0], 1'b0};
              ebits_r <= ebits_r - EW'(1);
              if (ebits_r == EW'(1)) begin
                out_valid_r <= 1'b1;
                out_power_r <= mm_res;
                state_r     <= S_IDLE;
              end
            end
          end
        end
        S_MUL: begin
          if (mm_done) begin
            e_r     <= {e_r[WORD_BITS-2:0], 1'b0};
            ebits_r <= ebits_r - EW'(1);
            if (ebits_r == EW'(1)) begin
              out_valid_r <= 1'b1;
              out_power_r <= mm_res;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_SQR;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation: directed key and base corners, then random traffic.
module tb;
  import modexp_pkg::*;

  localparam int W = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] TOP_BIT = {1'b1, {(W-1){1'b0}}};
  // indexes past the modulus register; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [W-1:0] in_base = '0;
  logic out_valid;
  logic [W-1:0] out_power;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;

  // shadow copy of the key registers, reset values
  logic [W-1:0] key_exp = 1;
  logic [W-1:0] key_mod = ALL_ONES;
  logic [W-1:0] expected_power[$];
  int mismatch_count = 0;
  int idle_pct = 0;

  modular_exponentiation #(.WORD_BITS(W)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_base  (in_base),
    .out_valid(out_valid),
    .out_power(out_power),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // right-to-left binary powering with full-width products
  function automatic logic [W-1:0] predict_power(input logic [W-1:0] b, input logic [W-1:0] e,
                                                 input logic [W-1:0] m);
    logic [2*W-1:0] m_wide;
    logic [2*W-1:0] acc;
    logic [2*W-1:0] sq;
    if (m == '0)
      return '0;
    m_wide = {{W{1'b0}}, m};
    acc = {{(2*W-1){1'b0}}, 1'b1} % m_wide;
    sq = {{W{1'b0}}, b} % m_wide;
    for (int i = 0; i < W; i++) begin
      if (e[i])
        acc = (acc * sq) % m_wide;
      sq = (sq * sq) % m_wide;
    end
    return acc[W-1:0];
  endfunction

  // leaves cfg_we high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_EXPONENT: key_exp = val;
      REG_MODULUS:  key_mod = val;
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [W-1:0] e, input logic [W-1:0] m);
    write_reg(REG_EXPONENT, e);
    write_reg(REG_MODULUS, m);
    cfg_we <= 1'b0;
  endtask

  // start stays high on return so a following transfer can go back to back
  task automatic send_base(input logic [W-1:0] b);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(1) == 1)
        while (busy) @(posedge clk);
      gap = $urandom_range(24, 1);
      repeat (gap) @(posedge clk);
    end
    in_base <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_power = {expected_power, predict_power(b, key_exp, key_mod)};
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_power.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_power.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: power %h with no transfer pending", $time, out_power);
      end else begin
        if (out_power !== expected_power[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: power expected %h got %h", $time, expected_power[0], out_power);
        end
        void'(expected_power.pop_front());
      end
    end
  end

  task automatic test_reset_key();
    send_base('0);
    send_base(1);
    send_base(ALL_ONES);
    send_base(ALL_ONES - 1);
    send_base(TOP_BIT);
    wait_idle();
  endtask

  task automatic test_exponent_zero();
    load_key('0, rand64() | TOP_BIT);
    send_base('0);
    send_base(ALL_ONES);
    wait_idle();
    // 1 mod 1 is zero
    load_key('0, 1);
    send_base(rand64());
    wait_idle();
  endtask

  task automatic test_modulus_edges();
    load_key(rand64(), 1);
    send_base(rand64());
    wait_idle();
    load_key(rand64(), '0);
    send_base(rand64());
    wait_idle();
    load_key(ALL_ONES, 2);
    send_base(rand64() | 1);
    send_base(rand64() & ~64'd1);
    wait_idle();
  endtask

  task automatic test_full_exponent();
    load_key(ALL_ONES, ALL_ONES);
    send_base(ALL_ONES - 1);
    send_base(2);
    wait_idle();
    load_key(TOP_BIT, rand64() | TOP_BIT | 1);
    send_base(3);
    wait_idle();
  endtask

  task automatic test_spare_index();
    write_reg(REG_EXPONENT, 1);
    write_reg(REG_MODULUS, 64'd1000003);
    write_reg(REG_SPARE_LO, rand64());
    write_reg(REG_SPARE_HI, rand64());
    cfg_we <= 1'b0;
    // exponent one still reduces a base above the modulus
    send_base(ALL_ONES);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int pct_by_phase[3] = '{0, 54, 13};
    logic [W-1:0] e;
    logic [W-1:0] m;
    logic [W-1:0] b;
    int nbits;
    int items;
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pct_by_phase[ph % 3];
      // full-width exponents are slow, so only a couple of short phases use them
      if (ph == 4 || ph == 7) begin
        e = rand64();
        items = 8;
      end else begin
        nbits = $urandom_range(16, 1);
        e = rand64() & (ALL_ONES >> (W - nbits));
        items = 14;
      end
      case ($urandom_range(3))
        0:       m = rand64() >> $urandom_range(W - 2);
        1:       m = rand64() | 1;
        default: m = rand64() | TOP_BIT;
      endcase
      load_key(e, m);
      repeat (items) begin
        case ($urandom_range(7))
          0:       b = '0;
          1:       b = 1;
          2:       b = m - 1;
          3:       b = ALL_ONES;
          4:       b = m;
          default: b = rand64();
        endcase
        send_base(b);
      end
      wait_idle();
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_key();
    test_exponent_zero();
    test_modulus_edges();
    test_full_exponent();
    test_spare_index();
    test_random_traffic();
    wait_idle();
    mismatch_count += expected_power.size();
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
hdl/modexp_pkg.sv
hdl/modexp_mulmod.sv
hdl/modular_exponentiation.sv
tb/sv/tb.sv
